/* rtl/epoch_seconds_to_calendar_defines.svh */
// Assertion macros shared by the RTL of the epoch-to-calendar converter.
// No dependencies; the asserting module includes this file by name.
`ifndef EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH
`define EPOCH_SECONDS_TO_CALENDAR_DEFINES_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define EP2CAL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked at every rising clock edge out of reset.
`define EP2CAL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ep2cal_pkg.sv */
// Constants and types for the epoch-to-calendar converter.
// No dependencies; imported by epoch_seconds_to_calendar.
`default_nettype none

package ep2cal_pkg;

    localparam int unsigned SECS_W  = 32;
    localparam int unsigned DAYS_W  = 16;   // at most 49710 whole days
    localparam int unsigned REST_W  = 17;   // seconds within a day, below 86400
    localparam int unsigned YEAR_W  = 12;
    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned HOUR_W  = 5;
    localparam int unsigned MIN_W   = 6;
    localparam int unsigned SEC_W   = 6;

    localparam int unsigned IN_TDATA_W  = 32;
    localparam int unsigned OUT_TDATA_W = 40;

    // Seconds per day is 128 * 675; the quotient by 675 uses a rounded-up
    // reciprocal scaled by 2^35, which is exact for any 25-bit dividend.
    localparam logic [25:0] RECIP_675   = 26'd50903317;
    localparam logic [16:0] SECS_DAY    = 17'd86400;
    // Four-year cycle of 1461 days; reciprocal scaled by 2^26, exact here.
    localparam logic [15:0] RECIP_1461  = 16'd45934;
    localparam logic [10:0] DAYS_CYCLE  = 11'd1461;
    // Hours: (rest / 16) / 225, reciprocal scaled by 2^20.
    localparam logic [12:0] RECIP_225   = 13'd4661;
    localparam logic [11:0] SECS_HOUR   = 12'd3600;
    // Minutes: (rest / 4) / 15, reciprocal scaled by 2^16.
    localparam logic [12:0] RECIP_15    = 13'd4370;
    localparam logic [5:0]  SECS_MIN    = 6'd60;

    localparam logic [YEAR_W-1:0] FIRST_YEAR = 12'd1970;

    // Day-of-year boundaries of the first three years in a cycle.
    // The cycle starts at 1970: two common years, one leap year, one common.
    localparam logic [10:0] CYC_Y1 = 11'd365;
    localparam logic [10:0] CYC_Y2 = 11'd730;
    localparam logic [10:0] CYC_Y3 = 11'd1096;
    localparam logic [1:0]  LEAP_OFFSET = 2'd2;

    // First day of each month in a common year, counted from zero.
    localparam logic [8:0] MONTH_START [12] = '{
        9'd0,   9'd31,  9'd59,  9'd90,  9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };

    typedef struct packed {
        logic [SEC_W-1:0]   second;
        logic [MIN_W-1:0]   minute;
        logic [HOUR_W-1:0]  hour;
        logic [DAY_W-1:0]   day_of_month;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } t_calendar;

endpackage

`default_nettype wire

/* rtl/epoch_seconds_to_calendar.sv */
// Converter from a 32-bit seconds-since-1970 count to year, month, day,
// hour, minute and second. Depends on ep2cal_pkg and the defines header.
`default_nettype none

// epoch_seconds_to_calendar is a seven-stage pipeline. A request enters on the
// s_axis side, its calendar result leaves on the m_axis side, and a new request
// can be taken in every cycle unless the output stalls. The whole pipeline
// moves as one: it advances whenever its last stage is empty or the result
// there is being taken, so a stalled output holds every stage in place and
// nothing is lost or repeated. Divisions by constants are done with exact
// reciprocal products; each stage has one multiply, stage 2 two, all registered:
// stage 1 splits whole days, stage 2 forms the day product and the four-year
// cycle count, stage 3 gives the second of the day and the day within the
// cycle, stage 4 gives the hour and the year, stage 5 the month and day,
// stage 6 the minute and stage 7 the second. Every year divisible by four is
// a leap year, 2100 included. The block holds no state between requests.

module epoch_seconds_to_calendar
    import ep2cal_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    input  wire                    s_axis_tvalid,
    output logic                   s_axis_tready,
    // [31:0] epoch_seconds
    input  wire [IN_TDATA_W-1:0]   s_axis_tdata,

    output logic                   m_axis_tvalid,
    input  wire                    m_axis_tready,
    // [11:0] year, [15:12] month, [20:16] day_of_month, [25:21] hour,
    // [31:26] minute, [37:32] second, [39:38] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

`include "epoch_seconds_to_calendar_defines.svh"

    localparam int unsigned STAGES = 7;

    // Pipeline advance: the last stage is empty or its result is taken.
    logic              w_adv;
    logic [STAGES:1]   r_vld;
    logic [STAGES:1]   n_vld;

    // Stage 1
    logic [50:0]       w_p1;
    logic [DAYS_W-1:0] n_s1_days;
    logic [DAYS_W-1:0] r_s1_days;
    logic [REST_W-1:0] r_s1_lo;

    // Stage 2
    logic [32:0]       w_p2_day;
    logic [31:0]       w_p2_cyc;
    logic [REST_W-1:0] n_s2_dprod;
    logic [5:0]        n_s2_q4;
    logic [REST_W-1:0] r_s2_dprod;
    logic [5:0]        r_s2_q4;
    logic [DAYS_W-1:0] r_s2_days;
    logic [REST_W-1:0] r_s2_lo;

    // Stage 3
    logic [16:0]       w_p3;
    logic [15:0]       w_doy4_full;
    logic [REST_W-1:0] n_s3_rest;
    logic [10:0]       n_s3_doy4;
    logic [REST_W-1:0] r_s3_rest;
    logic [10:0]       r_s3_doy4;
    logic [5:0]        r_s3_q4;

    // Stage 4
    logic [25:0]       w_p4;
    logic [1:0]        w_yoff;
    logic [10:0]       w_ybase;
    logic [HOUR_W-1:0] n_s4_hour;
    logic [YEAR_W-1:0] n_s4_year;
    logic [8:0]        n_s4_dy;
    logic              n_s4_leap;
    logic [REST_W-1:0] r_s4_rest;
    logic [HOUR_W-1:0] r_s4_hour;
    logic [YEAR_W-1:0] r_s4_year;
    logic [8:0]        r_s4_dy;
    logic              r_s4_leap;

    // Stage 5
    logic [16:0]        w_p5;
    logic [8:0]         w_mstart;
    logic [11:0]        n_s5_remh;
    logic [MONTH_W-1:0] n_s5_month;
    logic [DAY_W-1:0]   n_s5_day;
    logic [11:0]        r_s5_remh;
    logic [HOUR_W-1:0]  r_s5_hour;
    logic [YEAR_W-1:0]  r_s5_year;
    logic [MONTH_W-1:0] r_s5_month;
    logic [DAY_W-1:0]   r_s5_day;

    // Stage 6
    logic [22:0]        w_p6;
    logic [MIN_W-1:0]   n_s6_min;
    logic [MIN_W-1:0]   r_s6_min;
    logic [11:0]        r_s6_remh;
    logic [HOUR_W-1:0]  r_s6_hour;
    logic [YEAR_W-1:0]  r_s6_year;
    logic [MONTH_W-1:0] r_s6_month;
    logic [DAY_W-1:0]   r_s6_day;

    // Stage 7
    logic [11:0]        w_p7;
    t_calendar          n_out;
    t_calendar          r_out;

    assign w_adv         = !r_vld[STAGES] || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign m_axis_tvalid = r_vld[STAGES];
    assign m_axis_tdata  = {{(OUT_TDATA_W - $bits(t_calendar)){1'b0}}, r_out};

    always_comb begin
        n_vld = {r_vld[STAGES-1:1], s_axis_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_adv) begin
            r_vld <= n_vld;
        end
    end

    // Stage 1: whole days = (seconds / 128) / 675.
    always_comb begin
        w_p1      = 51'(s_axis_tdata[31:7]) * 51'(RECIP_675);
        n_s1_days = w_p1[50:35];
    end

    // Stage 2: day count times 86400 (only the low bits matter, since the
    // difference is below 86400) and the number of whole four-year cycles.
    always_comb begin
        w_p2_day   = 33'(r_s1_days) * 33'(SECS_DAY);
        w_p2_cyc   = 32'(r_s1_days) * 32'(RECIP_1461);
        n_s2_dprod = w_p2_day[REST_W-1:0];
        n_s2_q4    = w_p2_cyc[31:26];
    end

    // Stage 3: second of the day, and day within the four-year cycle.
    always_comb begin
        w_p3        = 17'(r_s2_q4) * 17'(DAYS_CYCLE);
        n_s3_rest   = r_s2_lo - r_s2_dprod;
        w_doy4_full = r_s2_days - w_p3[15:0];
        n_s3_doy4   = w_doy4_full[10:0];
    end

    // Stage 4: hour, and which year of the cycle holds the day.
    always_comb begin
        w_p4      = 26'(r_s3_rest[16:4]) * 26'(RECIP_225);
        n_s4_hour = w_p4[24:20];
        if (r_s3_doy4 >= CYC_Y3) begin
            w_yoff  = 2'd3;
            w_ybase = CYC_Y3;
        end else if (r_s3_doy4 >= CYC_Y2) begin
            w_yoff  = 2'd2;
            w_ybase = CYC_Y2;
        end else if (r_s3_doy4 >= CYC_Y1) begin
            w_yoff  = 2'd1;
            w_ybase = CYC_Y1;
        end else begin
            w_yoff  = 2'd0;
            w_ybase = '0;
        end
        n_s4_dy   = 9'(r_s3_doy4 - w_ybase);
        n_s4_leap = (w_yoff == LEAP_OFFSET);
        n_s4_year = FIRST_YEAR + {4'd0, r_s3_q4, 2'd0} + {10'd0, w_yoff};
    end

    // Stage 5: seconds within the hour, month and day of month. A leap year
    // pushes every month after February one day later.
    always_comb begin
        w_p5       = 17'(r_s4_hour) * 17'(SECS_HOUR);
        n_s5_remh  = 12'(r_s4_rest - w_p5);
        n_s5_month = 4'd1;
        w_mstart   = '0;
        for (int m = 1; m < 12; m++) begin
            if (r_s4_dy >= MONTH_START[m] + ((m >= 2 && r_s4_leap) ? 9'd1 : 9'd0)) begin
                n_s5_month = 4'(m + 1);
                w_mstart   = MONTH_START[m] + ((m >= 2 && r_s4_leap) ? 9'd1 : 9'd0);
            end
        end
        n_s5_day = 5'(r_s4_dy - w_mstart + 9'd1);
    end

    // Stage 6: minute = (seconds in hour / 4) / 15.
    always_comb begin
        w_p6     = 23'(r_s5_remh[11:2]) * 23'(RECIP_15);
        n_s6_min = w_p6[21:16];
    end

    // Stage 7: second of the minute, and the packed result.
    always_comb begin
        w_p7                = 12'(r_s6_min) * 12'(SECS_MIN);
        n_out.second        = 6'(r_s6_remh - w_p7);
        n_out.minute        = r_s6_min;
        n_out.hour          = r_s6_hour;
        n_out.day_of_month  = r_s6_day;
        n_out.month         = r_s6_month;
        n_out.year          = r_s6_year;
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_days  <= n_s1_days;
            r_s1_lo    <= s_axis_tdata[REST_W-1:0];

            r_s2_dprod <= n_s2_dprod;
            r_s2_q4    <= n_s2_q4;
            r_s2_days  <= r_s1_days;
            r_s2_lo    <= r_s1_lo;

            r_s3_rest  <= n_s3_rest;
            r_s3_doy4  <= n_s3_doy4;
            r_s3_q4    <= r_s2_q4;

            r_s4_rest  <= r_s3_rest;
            r_s4_hour  <= n_s4_hour;
            r_s4_year  <= n_s4_year;
            r_s4_dy    <= n_s4_dy;
            r_s4_leap  <= n_s4_leap;

            r_s5_remh  <= n_s5_remh;
            r_s5_hour  <= r_s4_hour;
            r_s5_year  <= r_s4_year;
            r_s5_month <= n_s5_month;
            r_s5_day   <= n_s5_day;

            r_s6_min   <= n_s6_min;
            r_s6_remh  <= r_s5_remh;
            r_s6_hour  <= r_s5_hour;
            r_s6_year  <= r_s5_year;
            r_s6_month <= r_s5_month;
            r_s6_day   <= r_s5_day;

            r_out      <= n_out;
        end
    end

    // A held pipeline keeps its occupancy unchanged.
    `EP2CAL_ASSERT_NEXT(a_stall_holds, i_clk, i_rst_n, !w_adv, $stable(r_vld), "stall moved pipeline")
    // An advance shifts occupancy by exactly one stage.
    `EP2CAL_ASSERT_NEXT(a_adv_shift, i_clk, i_rst_n, w_adv, r_vld[STAGES] == $past(r_vld[STAGES-1]), "occupancy lost")
    // Results leaving the block have a month from 1 to 12 and a day from 1 to 31.
    `EP2CAL_ASSERT_NOW(a_date_range, i_clk, i_rst_n, m_axis_tvalid, r_out.month >= 4'd1 && r_out.month <= 4'd12 && r_out.day_of_month >= 5'd1 && r_out.day_of_month <= 5'd31, "date out of range")
    // Results leaving the block are valid times of day.
    `EP2CAL_ASSERT_NOW(a_time_range, i_clk, i_rst_n, m_axis_tvalid, r_out.hour < 5'd24 && r_out.minute < 6'd60 && r_out.second < 6'd60, "time out of range")

endmodule

`default_nettype wire

/* tb/sv/epoch_seconds_to_calendar_tb.sv */
// Self-checking testbench for the seconds-since-1970 to calendar converter.
// Depends on ep2cal_pkg and the epoch_seconds_to_calendar RTL only.
`timescale 1ns / 100ps

module epoch_seconds_to_calendar_tb;
    import ep2cal_pkg::*;

    // Cycles without any accepted request or result before the run is declared hung.
    localparam int unsigned STALL_LIMIT = 5000;
    // Pipeline depth of the block, with some margin for the final wait.
    localparam int unsigned DRAIN_CYCLES = 12;
    localparam int unsigned RANDOM_REQUESTS = 1700;
    localparam int unsigned SECS_PER_DAY = 86400;
    localparam int unsigned LAST_FULL_DAY = 49709;

    // Scoreboard: turns each accepted request into the calendar date it must
    // produce and checks results against those dates in arrival order.
    class calendar_scoreboard;
        t_calendar   dates_due[$];
        int unsigned fail_count;

        function new();
            fail_count = 0;
        endfunction

        function int unsigned pending();
            return dates_due.size();
        endfunction

        // Year length under the plain divisible-by-four rule, so 2100 is a leap year.
        function int unsigned year_length(int unsigned yr);
            return (yr % 4 == 0) ? 366 : 365;
        endfunction

        function t_calendar calendar_of(logic [SECS_W-1:0] secs);
            t_calendar   cal;
            int unsigned days;
            int unsigned rest;
            int unsigned yr;
            int unsigned mon;
            int unsigned mlen;
            days       = secs / SECS_PER_DAY;
            rest       = secs % SECS_PER_DAY;
            cal.hour   = HOUR_W'(rest / 3600);
            cal.minute = MIN_W'((rest % 3600) / 60);
            cal.second = SEC_W'(rest % 60);
            yr = 1970;
            while (days >= year_length(yr)) begin
                days -= year_length(yr);
                yr++;
            end
            mon = 1;
            while (mon < 12) begin
                if (mon == 2) begin
                    mlen = (yr % 4 == 0) ? 29 : 28;
                end else if (mon == 4 || mon == 6 || mon == 9 || mon == 11) begin
                    mlen = 30;
                end else begin
                    mlen = 31;
                end
                if (days < mlen) begin
                    break;
                end
                days -= mlen;
                mon++;
            end
            cal.year         = YEAR_W'(yr);
            cal.month        = MONTH_W'(mon);
            cal.day_of_month = DAY_W'(days + 1);
            return cal;
        endfunction

        function void note_request(logic [SECS_W-1:0] secs);
            dates_due.push_back(calendar_of(secs));
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
                fail_count++;
            end
        endfunction

        function void check_result(logic [OUT_TDATA_W-1:0] word);
            t_calendar want;
            t_calendar got;
            if (dates_due.size() == 0) begin
                $display("%0t: result with no request waiting, expected none, actual %h",
                         $time, word);
                fail_count++;
                return;
            end
            want = dates_due.pop_front();
            got  = word[$bits(t_calendar)-1:0];
            compare_field("year",         want.year,         got.year);
            compare_field("month",        want.month,        got.month);
            compare_field("day_of_month", want.day_of_month, got.day_of_month);
            compare_field("hour",         want.hour,         got.hour);
            compare_field("minute",       want.minute,       got.minute);
            compare_field("second",       want.second,       got.second);
            compare_field("tdata padding", 0, word[OUT_TDATA_W-1:$bits(t_calendar)]);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    // While set, neither the request side nor the result side inserts idle cycles.
    bit                     no_idle = 1'b0;
    int unsigned            quiet_cycles = 0;
    calendar_scoreboard     sb = new();

    epoch_seconds_to_calendar u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [31:0] epoch_seconds
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)    // [11:0] year .. [37:32] second, [39:38] zero
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // The result side stalls at random with a probability of about 7 percent, except in the quiet stretch.
    always @(negedge i_clk) begin
        m_axis_tready <= no_idle || ($urandom_range(0, 99) >= 7);
    end

    // Everything is observed at the rising edge. A request is noted before any
    // result of the same edge is checked, so the order of processes does not matter.
    // The same block runs the watchdog on cycles where nothing moves.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_request(s_axis_tdata);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_result(m_axis_tdata);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // Presents one request. Any idle cycles come first with tvalid low; once
    // tvalid is raised it stays up until the request is taken, and the task
    // returns at that rising edge so the next request can follow back to back.
    task automatic send_request(input logic [SECS_W-1:0] secs);
        @(negedge i_clk);
        while (!no_idle && $urandom_range(0, 99) < 7) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= secs;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    // Drops tvalid and holds off until every outstanding date has come back.
    task automatic wait_for_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random seconds: half fully random words; of the rest two thirds land on or
    // next to a midnight so that day, month and year rollovers come up often,
    // with a share of them in the last decades where the 2100 leap day matters.
    function automatic logic [SECS_W-1:0] random_seconds();
        int unsigned day;
        int unsigned offset;
        if ($urandom_range(0, 1) == 0) begin
            return $urandom();
        end
        if ($urandom_range(0, 3) == 0) begin
            day = $urandom_range(45000, LAST_FULL_DAY);
        end else begin
            day = $urandom_range(0, LAST_FULL_DAY);
        end
        case ($urandom_range(0, 2))
            0: offset = 0;
            1: offset = SECS_PER_DAY - 1;
            default: offset = $urandom_range(0, SECS_PER_DAY - 1);
        endcase
        return day * SECS_PER_DAY + offset;
    endfunction

    // Directed requests: the ends of the range, minute, hour and day rollovers,
    // the end of the first year, the 1972 leap day and year end, the 2038
    // sign boundary, and the 2100 leap day that the simple rule keeps.
    localparam logic [SECS_W-1:0] DIRECTED [24] = '{
        32'd0,          32'd59,         32'd60,         32'd3599,
        32'd3600,       32'd86399,      32'd86400,      32'd31535999,
        32'd31536000,   32'd68083200,   32'd68169600,   32'd68256000,
        32'd94694399,   32'd94694400,   32'h7FFF_FFFF,  32'h8000_0000,
        32'd4107456000, 32'd4107542400, 32'd4107628800, 32'd4134067199,
        32'hAAAA_AAAA,  32'h5555_5555,  32'hFFFF_FFFE,  32'hFFFF_FFFF
    };

    initial begin
        int unsigned n;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (DIRECTED[k]) begin
            send_request(DIRECTED[k]);
        end
        // Let the pipeline empty completely once before the random part.
        wait_for_results();

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            no_idle = (n >= 500 && n < 900);
            if (n == 1200) begin
                wait_for_results();
            end
            send_request(random_seconds());
        end
        no_idle = 1'b0;

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.pending() != 0) begin
            $display("%0t: %0d expected dates never arrived", $time, sb.pending());
        end
        if (sb.fail_count == 0 && sb.pending() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ep2cal_pkg.sv
rtl/epoch_seconds_to_calendar.sv
tb/sv/epoch_seconds_to_calendar_tb.sv
